// ----- sv/pscc_pkg.sv -----
// ============================================================================
// pscc_pkg
// Shared constants and state type for the palindromic substring counter.
// ============================================================================
package pscc_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int CTR_W    = LEN_W;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 20;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CENTER,
        ST_PROBE,
        ST_CMP,
        ST_OUT
    } state_t;

endpackage

// ----- sv/palindromic_substring_counter_core.sv -----
// ============================================================================
// palindromic_substring_counter_core
// Buffers a string and counts its palindromic substrings by center expansion.
// ============================================================================
//
//  Channel | Direction | Payload                               | Framing
//  --------+-----------+---------------------------------------+-------------------
//  s_*     | in        | s_tdata[7:0] = char_code              | s_tlast = is_last
//  m_*     | out       | m_tdata[19:0] = pal_count,            | one per string
//          |           | m_tdata[20] = overflow, [23:21] = 0   |
//
//  Characters load at one transaction per cycle, while the block is in its
//  load state, into a 1024 x 8 buffer RAM. After the final character the
//  walk visits each center in turn: the expansion ends when it runs off an
//  end of the string or stops on a mismatch; each character pair is read
//  from the two-port RAM and then compared. The output state then moves the
//  result into the output register, and loading resumes.
//  rst_n clears all control state; the RAM content is never cleared because
//  only entries written for the current string are read.
//  A stalled m_tready holds the result; the block holds in its output state
//  only while an earlier result still occupies the output register.
//
module palindromic_substring_counter_core
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pscc_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] char_code
    input  logic                               s_tlast,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pscc_pkg::OUT_DATA_W-1:0]    m_tdata    // [19:0] pal_count, [20] overflow
);

    pscc_pkg::state_t state_reg, state_next;

    logic [pscc_pkg::LEN_W-1:0]  length_reg, length_next;
    logic [pscc_pkg::CTR_W-1:0]  center_reg, center_next;
    logic [pscc_pkg::LEN_W-1:0]  left_reg, left_next;     // held one above the true index
    logic [pscc_pkg::LEN_W-1:0]  right_reg, right_next;
    logic [pscc_pkg::CNT_W-1:0]  total_reg, total_next;
    logic                        drop_reg, drop_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [pscc_pkg::CNT_W-1:0]  out_count_reg;
    logic                        out_ovf_reg;
    logic                        out_load;

    // Buffer RAM with one write and two read ports.
    logic [pscc_pkg::CHAR_W-1:0] buf_mem [pscc_pkg::MAX_LEN];
    logic                        wr_en;
    logic [pscc_pkg::ADDR_W-1:0] wr_addr;
    logic                        rd_en;
    logic [pscc_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [pscc_pkg::CHAR_W-1:0] rd_a_reg, rd_b_reg;

    logic                        s_accept;
    logic                        in_bounds;
    logic [pscc_pkg::LEN_W:0]    last_center;
    logic [pscc_pkg::LEN_W-1:0]  left_dec;

    assign s_tready = (state_reg == pscc_pkg::ST_LOAD);
    assign s_accept = s_tvalid && s_tready;

    assign in_bounds   = (left_reg != '0) && (right_reg < length_reg);
    assign last_center = {length_reg, 1'b0} - (pscc_pkg::LEN_W + 1)'(2);
    assign left_dec    = left_reg - pscc_pkg::LEN_W'(1);

    assign wr_addr   = length_reg[pscc_pkg::ADDR_W-1:0];
    assign rd_addr_a = left_dec[pscc_pkg::ADDR_W-1:0];
    assign rd_addr_b = right_reg[pscc_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_addr] <= s_tdata[pscc_pkg::CHAR_W-1:0];
        end
        if (rd_en)
        begin
            rd_a_reg <= buf_mem[rd_addr_a];
            rd_b_reg <= buf_mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pscc_pkg::ST_LOAD;
            length_reg   <= '0;
            center_reg   <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            total_reg    <= '0;
            drop_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            length_reg   <= length_next;
            center_reg   <= center_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            total_reg    <= total_next;
            drop_reg     <= drop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_count_reg <= total_reg;
            out_ovf_reg   <= drop_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        length_next   = length_reg;
        center_next   = center_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        total_next    = total_reg;
        drop_next     = drop_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            pscc_pkg::ST_LOAD:
            begin
                if (s_accept)
                begin
                    // Store while room remains, otherwise drop and flag.
                    if (length_reg < pscc_pkg::LEN_W'(pscc_pkg::MAX_LEN))
                    begin
                        wr_en       = 1'b1;
                        length_next = length_reg + pscc_pkg::LEN_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        center_next = '0;
                        total_next  = '0;
                        state_next  = pscc_pkg::ST_CENTER;
                    end
                end
            end

            pscc_pkg::ST_CENTER:
            begin
                // Odd centers sit between two characters.
                left_next  = pscc_pkg::LEN_W'(center_reg[pscc_pkg::CTR_W-1:1])
                             + pscc_pkg::LEN_W'(1);
                right_next = pscc_pkg::LEN_W'(center_reg[pscc_pkg::CTR_W-1:1])
                             + pscc_pkg::LEN_W'(center_reg[0]);
                state_next = pscc_pkg::ST_PROBE;
            end

            pscc_pkg::ST_PROBE:
            begin
                if (in_bounds)
                begin
                    rd_en      = 1'b1;
                    state_next = pscc_pkg::ST_CMP;
                end
                else if (center_reg == last_center[pscc_pkg::CTR_W-1:0])
                begin
                    state_next = pscc_pkg::ST_OUT;
                end
                else
                begin
                    center_next = center_reg + pscc_pkg::CTR_W'(1);
                    state_next  = pscc_pkg::ST_CENTER;
                end
            end

            pscc_pkg::ST_CMP:
            begin
                if (rd_a_reg == rd_b_reg)
                begin
                    if (total_reg < pscc_pkg::COUNT_MAX)
                    begin
                        total_next = total_reg + pscc_pkg::CNT_W'(1);
                    end
                    left_next  = left_dec;
                    right_next = right_reg + pscc_pkg::LEN_W'(1);
                    state_next = pscc_pkg::ST_PROBE;
                end
                else if (center_reg == last_center[pscc_pkg::CTR_W-1:0])
                begin
                    state_next = pscc_pkg::ST_OUT;
                end
                else
                begin
                    center_next = center_reg + pscc_pkg::CTR_W'(1);
                    state_next  = pscc_pkg::ST_CENTER;
                end
            end

            pscc_pkg::ST_OUT:
            begin
                // Hand off once the output register is free, then clear.
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load    = 1'b1;
                    length_next = '0;
                    total_next  = '0;
                    drop_next   = 1'b0;
                    center_next = '0;
                    left_next   = '0;
                    right_next  = '0;
                    state_next  = pscc_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = pscc_pkg::ST_LOAD;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(pscc_pkg::OUT_DATA_W - pscc_pkg::CNT_W - 1){1'b0}},
                       out_ovf_reg, out_count_reg};

    // Compare always follows a read issued from the probe state.
    a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pscc_pkg::ST_CMP |-> $past(state_reg) == pscc_pkg::ST_PROBE)
        else $error("compare without a preceding read");

    // Pointers used in a compare lie inside the stored string.
    a_cmp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pscc_pkg::ST_CMP |-> (left_reg != '0) && (right_reg < length_reg))
        else $error("compare outside the stored string");

    // Stored length never exceeds the buffer depth.
    a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= pscc_pkg::LEN_W'(pscc_pkg::MAX_LEN))
        else $error("stored length beyond buffer depth");

    // Leaving the output state always loads a fresh result.
    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pscc_pkg::ST_OUT && state_next == pscc_pkg::ST_LOAD)
        |=> m_tvalid_reg && length_reg == '0 && total_reg == '0)
        else $error("result not posted or counters not cleared");

endmodule
